@@ rtl/rotation_matrix_to_quaternion_defines.svh @@
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: assertion macros
// Shared check macros for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// check that is switched off while reset is applied
`define RMQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check that also runs through reset
`define RMQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: package
// Widths, axis codes and pipeline payload types.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // number format
    localparam int FRAC_BITS = 14;
    localparam int ELEM_W    = 16;
    localparam int N_ELEM    = 9;
    localparam int N_QUAT    = 4;
    localparam int IN_W      = ELEM_W * N_ELEM;
    localparam int OUT_W     = ELEM_W * N_QUAT;

    // root argument, signed, holds trace plus one and the axis arguments
    localparam int A_W   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    // radicand and root
    localparam int R_W   = A_W - 1 + FRAC_BITS;
    localparam int SQ_W  = (R_W + 1) / 2;
    localparam int RAD_W = 2 * SQ_W;
    // divisor is twice the root
    localparam int D_W   = SQ_W + 1;
    localparam int REM_W = D_W + 1;
    // element sums and differences
    localparam int DIF_W = ELEM_W + 1;
    localparam int N_W   = DIF_W + FRAC_BITS;
    // quotient bits below the saturation point
    localparam int Q_STEPS = ELEM_W - 1;

    // payload stages: select, root steps, overflow check, quotient steps
    localparam int PL_N = 1 + SQ_W + 1 + Q_STEPS;
    // all stages: front, payload stages, format
    localparam int NST  = 1 + PL_N + 1;

    localparam logic signed [ELEM_W-1:0] Q_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic signed [ELEM_W-1:0] Q_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    // axis codes; w marks the positive trace case
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [1:0] AXIS_W = 2'd3;

    typedef struct packed {
        logic                        pos;
        logic [1:0]                  ax;
        logic signed [A_W-1:0]       arg_pos;
        logic [2:0][A_W-1:0]         arg_ax;
        logic [2:0][DIF_W-1:0]       dif;
        logic [2:0][DIF_W-1:0]       sum;
    } front_t;

    typedef struct packed {
        logic                        degen;
        logic [1:0]                  main;
        logic [2:0]                  neg;
        logic [RAD_W-1:0]            rad;
        logic [SQ_W+1:0]             srem;
        logic [SQ_W-1:0]             root;
        logic [2:0][N_W-1:0]         num;
        logic [2:0][REM_W-1:0]       drem;
        logic [2:0]                  ov;
        logic [2:0][Q_STEPS-1:0]     quo;
    } pl_t;

    typedef struct packed {
        logic                        degen;
        logic [N_QUAT-1:0][ELEM_W-1:0] quat;
    } res_t;

endpackage

@@ rtl/rotation_matrix_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion
// Shoemake conversion of a 3x3 rotation matrix to a unit quaternion.
// ----------------------------------------------------------------------------
// channel   | dir | ports                  | content
// ----------+-----+------------------------+------------------------------------
// matrix in | in  | s_tvalid/tready/tdata  | m00..m22, 16 bit each
// quat out  | out | m_tvalid/tready/tdata  | quat_x..quat_w, tuser: degenerate
//
// one item per cycle while the skid register is free; 36 register stages (front,
// select, 16 root steps, overflow check, 15 quotient steps, format, output
// register)
// the root and the three quotients are worked one bit per pipeline stage
// reset (aresetn low) empties the pipeline and the output buffers
// a stall on the output fills a skid register, then halts the pipeline

module rotation_matrix_to_quaternion (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    input  logic [rmq_pkg::IN_W-1:0]     s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // quat_x, quat_y, quat_z, quat_w
    output logic [rmq_pkg::OUT_W-1:0]    m_tdata,
    // degenerate
    output logic [0:0]                   m_tuser
);
    import rmq_pkg::*;

    `include "rotation_matrix_to_quaternion_defines.svh"

    localparam logic signed [A_W-1:0] ONE = A_W'(1) <<< FRAC_BITS;

    logic            en;
    logic [NST-1:0]  vld_reg;
    front_t          front_reg, front_next;
    pl_t             pl_reg  [PL_N];
    pl_t             pl_next [PL_N];
    res_t            fmt_reg, fmt_next;
    res_t            out_reg, skid_reg;
    logic            out_vld_reg, skid_vld_reg;

    // pipeline moves while the skid register is free
    assign en       = !skid_vld_reg;
    assign s_tready = en;

    // valid bits travel with the items
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    // front: trace, axis pick, candidate arguments, sums and differences
    always_comb begin
        logic signed [A_W-1:0] m [3][3];
        logic signed [A_W-1:0] tr;
        logic                  i1, i2;
        logic signed [A_W-1:0] mi;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                m[r][c] = A_W'($signed(s_tdata[ELEM_W*(3*r+c) +: ELEM_W]));
            end
        end
        tr = m[0][0] + m[1][1] + m[2][2];
        i1 = m[1][1] > m[0][0];
        mi = i1 ? m[1][1] : m[0][0];
        i2 = m[2][2] > mi;
        front_next.pos     = tr > 0;
        front_next.ax      = i2 ? AXIS_Z : (i1 ? AXIS_Y : AXIS_X);
        front_next.arg_pos = tr + ONE;
        front_next.arg_ax[0] = m[0][0] - m[1][1] - m[2][2] + ONE;
        front_next.arg_ax[1] = m[1][1] - m[2][2] - m[0][0] + ONE;
        front_next.arg_ax[2] = m[2][2] - m[0][0] - m[1][1] + ONE;
        front_next.dif[0] = DIF_W'(m[1][2] - m[2][1]);
        front_next.dif[1] = DIF_W'(m[2][0] - m[0][2]);
        front_next.dif[2] = DIF_W'(m[0][1] - m[1][0]);
        front_next.sum[0] = DIF_W'(m[1][2] + m[2][1]);
        front_next.sum[1] = DIF_W'(m[2][0] + m[0][2]);
        front_next.sum[2] = DIF_W'(m[0][1] + m[1][0]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            front_reg <= front_next;
        end
    end

    // select: root argument, lane values, magnitudes and signs
    always_comb begin
        logic signed [A_W-1:0]   a;
        logic signed [DIF_W-1:0] lane [3];
        logic [DIF_W-1:0]        mag;
        pl_next[0] = '0;
        a = front_reg.arg_pos;
        lane[0] = $signed(front_reg.dif[0]);
        lane[1] = $signed(front_reg.dif[1]);
        lane[2] = $signed(front_reg.dif[2]);
        pl_next[0].main = AXIS_W;
        if (!front_reg.pos) begin
            pl_next[0].main = front_reg.ax;
            case (front_reg.ax)
                AXIS_X: begin
                    a       = $signed(front_reg.arg_ax[0]);
                    lane[0] = $signed(front_reg.dif[0]);
                    lane[1] = $signed(front_reg.sum[2]);
                    lane[2] = $signed(front_reg.sum[1]);
                end
                AXIS_Y: begin
                    a       = $signed(front_reg.arg_ax[1]);
                    lane[0] = $signed(front_reg.dif[1]);
                    lane[1] = $signed(front_reg.sum[0]);
                    lane[2] = $signed(front_reg.sum[2]);
                end
                default: begin
                    a       = $signed(front_reg.arg_ax[2]);
                    lane[0] = $signed(front_reg.dif[2]);
                    lane[1] = $signed(front_reg.sum[1]);
                    lane[2] = $signed(front_reg.sum[0]);
                end
            endcase
        end
        pl_next[0].degen = a <= 0;
        pl_next[0].rad = pl_next[0].degen ? '0 :
            RAD_W'({a[A_W-2:0], {FRAC_BITS{1'b0}}});
        for (int l = 0; l < 3; l++) begin
            pl_next[0].neg[l] = lane[l] < 0;
            mag = pl_next[0].neg[l] ? DIF_W'(-lane[l]) : DIF_W'(lane[l]);
            pl_next[0].num[l] = N_W'({mag, {FRAC_BITS{1'b0}}});
        end
    end

    // square root, one result bit per stage
    for (genvar p = 1; p <= SQ_W; p++) begin : g_sqrt
        always_comb begin
            logic [SQ_W+1:0] rem_sh;
            logic [SQ_W+1:0] trial;
            logic            ge;
            pl_next[p] = pl_reg[p-1];
            rem_sh = {pl_reg[p-1].srem[SQ_W-1:0], pl_reg[p-1].rad[RAD_W-1 -: 2]};
            trial  = {pl_reg[p-1].root, 2'b01};
            ge     = rem_sh >= trial;
            pl_next[p].srem = ge ? (rem_sh - trial) : rem_sh;
            pl_next[p].root = {pl_reg[p-1].root[SQ_W-2:0], ge};
            pl_next[p].rad  = pl_reg[p-1].rad << 2;
        end
    end

    // overflow check: quotient at or above the saturation point
    always_comb begin
        logic [REM_W-1:0] rem0;
        logic [REM_W-1:0] dvs;
        pl_next[SQ_W+1] = pl_reg[SQ_W];
        dvs = REM_W'({pl_reg[SQ_W].root, 1'b0});
        for (int l = 0; l < 3; l++) begin
            rem0 = REM_W'(pl_reg[SQ_W].num[l][N_W-1:Q_STEPS]);
            pl_next[SQ_W+1].ov[l]   = rem0 >= dvs;
            pl_next[SQ_W+1].drem[l] = rem0;
            pl_next[SQ_W+1].quo[l]  = '0;
        end
    end

    // restoring division, one quotient bit per stage in each lane
    for (genvar p = SQ_W + 2; p < PL_N; p++) begin : g_div
        always_comb begin
            logic [REM_W-1:0] rem_sh;
            logic [REM_W-1:0] dvs;
            logic             ge;
            pl_next[p] = pl_reg[p-1];
            dvs = REM_W'({pl_reg[p-1].root, 1'b0});
            for (int l = 0; l < 3; l++) begin
                rem_sh = {pl_reg[p-1].drem[l][REM_W-2:0],
                          pl_reg[p-1].num[l][Q_STEPS-1]};
                ge = rem_sh >= dvs;
                pl_next[p].drem[l] = ge ? (rem_sh - dvs) : rem_sh;
                pl_next[p].quo[l]  = {pl_reg[p-1].quo[l][Q_STEPS-2:0], ge};
                pl_next[p].num[l]  = pl_reg[p-1].num[l] << 1;
            end
        end
    end

    for (genvar p = 0; p < PL_N; p++) begin : g_pl
        always_ff @(posedge aclk) begin
            if (en) begin
                pl_reg[p] <= pl_next[p];
            end
        end
    end

    // format: signs, saturation, placement of the components
    always_comb begin
        logic [ELEM_W-1:0] lv [3];
        logic [SQ_W-1:0]   half;
        logic [ELEM_W-1:0] mv;
        pl_t               f;
        f = pl_reg[PL_N-1];
        for (int l = 0; l < 3; l++) begin
            if (f.ov[l]) begin
                lv[l] = f.neg[l] ? Q_MIN : Q_MAX;
            end else begin
                lv[l] = f.neg[l] ? ELEM_W'(-{1'b0, f.quo[l]}) : ELEM_W'({1'b0, f.quo[l]});
            end
        end
        half = f.root >> 1;
        mv = (half > SQ_W'(Q_MAX)) ? Q_MAX : ELEM_W'(half);
        fmt_next.degen = f.degen;
        fmt_next.quat  = '0;
        case (f.main)
            AXIS_X: begin
                fmt_next.quat[0] = mv;
                fmt_next.quat[3] = lv[0];
                fmt_next.quat[1] = lv[1];
                fmt_next.quat[2] = lv[2];
            end
            AXIS_Y: begin
                fmt_next.quat[1] = mv;
                fmt_next.quat[3] = lv[0];
                fmt_next.quat[2] = lv[1];
                fmt_next.quat[0] = lv[2];
            end
            AXIS_Z: begin
                fmt_next.quat[2] = mv;
                fmt_next.quat[3] = lv[0];
                fmt_next.quat[0] = lv[1];
                fmt_next.quat[1] = lv[2];
            end
            default: begin
                fmt_next.quat[3] = mv;
                fmt_next.quat[0] = lv[0];
                fmt_next.quat[1] = lv[1];
                fmt_next.quat[2] = lv[2];
            end
        endcase
        if (f.degen) begin
            fmt_next.quat = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fmt_reg <= fmt_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (m_tready || !out_vld_reg) begin
            out_vld_reg  <= skid_vld_reg || vld_reg[NST-1];
            skid_vld_reg <= 1'b0;
        end else if (en && vld_reg[NST-1]) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !out_vld_reg) begin
            out_reg <= skid_vld_reg ? skid_reg : fmt_reg;
        end else if (en && vld_reg[NST-1]) begin
            skid_reg <= fmt_reg;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = out_reg.quat;
    assign m_tuser[0] = out_reg.degen;

    // checks
    `RMQ_ASSERT(a_degen_zero, m_tvalid && m_tuser[0] |-> m_tdata == '0, "degenerate item not zero")
    `RMQ_ASSERT(a_skid_order, skid_vld_reg |-> out_vld_reg, "skid holds item with empty output")
    `RMQ_ASSERT(a_root_nonzero, vld_reg[SQ_W+1] && !pl_reg[SQ_W].degen |-> pl_reg[SQ_W].root != '0, "zero root on valid item")
    `RMQ_ASSERT(a_div_rem, vld_reg[PL_N] && !pl_reg[PL_N-1].ov[0] |-> pl_reg[PL_N-1].drem[0] < REM_W'({pl_reg[PL_N-1].root, 1'b0}), "remainder not below divisor")
    `RMQ_ASSERT_ALWAYS(a_reset_empty, !$past(aresetn) |-> vld_reg == '0 && !m_tvalid, "pipeline not empty after reset")

endmodule

@@ tb/sv/rmq_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: result checker
// Watches both channels, works out the quaternion for every accepted matrix
// and compares each accepted result with the oldest one still waiting.
// ----------------------------------------------------------------------------

module rmq_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [rmq_pkg::IN_W-1:0]     s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [rmq_pkg::OUT_W-1:0]    m_tdata,
    input  logic [0:0]                   m_tuser,
    output int                           n_fail,
    output int                           n_waiting
);
    import rmq_pkg::*;

    typedef struct packed {
        logic                           degen;
        logic [N_QUAT-1:0][ELEM_W-1:0]  quat;
    } quat_res_t;

    quat_res_t quat_q[$];

    // integer square root, bit by bit
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint clamp16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // diff * one / (2 * root), truncated toward zero
    function automatic longint div_by_root(input longint d, input longint unsigned root);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? longint'(-d) : d;
        q = (mag << FRAC_BITS) / (2 * root);
        if (q > 65536) q = 65536;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic quat_res_t to_quat(input logic [IN_W-1:0] mat);
        longint m[3][3];
        longint q[4];
        longint tr;
        longint a;
        longint unsigned root;
        quat_res_t res;
        int i, jj, kk;
        for (int e = 0; e < 9; e++)
            m[e/3][e%3] = longint'($signed(mat[e*ELEM_W +: ELEM_W]));
        res.degen = 1'b0;
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0) begin
            root = int_sqrt(longint'(tr + (1 << FRAC_BITS)) << FRAC_BITS);
            q[3] = root >> 1;
            q[0] = div_by_root(m[1][2] - m[2][1], root);
            q[1] = div_by_root(m[2][0] - m[0][2], root);
            q[2] = div_by_root(m[0][1] - m[1][0], root);
        end else begin
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            jj = (i + 1) % 3;
            kk = (jj + 1) % 3;
            a = m[i][i] - m[jj][jj] - m[kk][kk] + (1 << FRAC_BITS);
            if (a <= 0) begin
                res.degen = 1'b1;
                q[0] = 0; q[1] = 0; q[2] = 0; q[3] = 0;
            end else begin
                root = int_sqrt(a << FRAC_BITS);
                q[i]  = root >> 1;
                q[3]  = div_by_root(m[jj][kk] - m[kk][jj], root);
                q[jj] = div_by_root(m[i][jj] + m[jj][i], root);
                q[kk] = div_by_root(m[i][kk] + m[kk][i], root);
            end
        end
        for (int c = 0; c < N_QUAT; c++)
            res.quat[c] = ELEM_W'(clamp16(q[c]));
        return res;
    endfunction

    // predict on input, compare on output
    always @(posedge aclk) begin
        quat_res_t exp_r;
        quat_res_t got;
        if (!aresetn) begin
            n_fail    <= 0;
            n_waiting <= 0;
        end else begin
            if (s_tvalid && s_tready)
                quat_q.push_back(to_quat(s_tdata));
            if (m_tvalid && m_tready) begin
                got.quat  = m_tdata;
                got.degen = m_tuser[0];
                if (quat_q.size() == 0) begin
                    if (n_fail < 10)
                        $display("unexpected result %h deg %b", got.quat, got.degen);
                    n_fail <= n_fail + 1;
                end else begin
                    exp_r = quat_q.pop_front();
                    if (exp_r != got) begin
                        if (n_fail < 10)
                            $display("mismatch: exp x %h y %h z %h w %h deg %b, got x %h y %h z %h w %h deg %b",
                                exp_r.quat[0], exp_r.quat[1], exp_r.quat[2], exp_r.quat[3],
                                exp_r.degen, got.quat[0], got.quat[1], got.quat[2],
                                got.quat[3], got.degen);
                        n_fail <= n_fail + 1;
                    end
                end
            end
            n_waiting <= quat_q.size();
        end
    end

endmodule

@@ tb/sv/tb_rotation_matrix_to_quaternion.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: testbench
// Directed corner matrices, then random near-rotations and raw
// bit patterns, with random idling on both channels; a checker judges results.
// ----------------------------------------------------------------------------

module tb_rotation_matrix_to_quaternion;
    import rmq_pkg::*;

    localparam int N_RAND    = 700;
    localparam int WDOG_MAX  = 2000;
    localparam logic [ELEM_W-1:0] ONE = 16'sd16384;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic [0:0]           m_tuser;
    int                   n_fail;
    int                   n_waiting;
    int                   idle_cnt;
    bit                   calm;

    rotation_matrix_to_quaternion u_top (.*);

    rmq_checker u_chk (.*);

    // clock
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // watchdog on cycles with no item moving
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG_MAX) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stalls in short bursts
    always @(negedge aclk) begin
        if (!calm && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        m_tready <= 1'b1;
    end

    // one matrix item, with an optional idle burst before it
    task automatic send_matrix(input logic [IN_W-1:0] mat);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mat;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [IN_W-1:0] pack9(input logic [8:0][ELEM_W-1:0] e);
        return e;
    endfunction

    // small random perturbation around a signed value
    function automatic logic [ELEM_W-1:0] jitter(input int v);
        return ELEM_W'(v + int'($urandom_range(0, 64)) - 32);
    endfunction

    // permuted signed unit matrix with noise: reaches every axis and sign
    function automatic logic [IN_W-1:0] near_rotation();
        logic [8:0][ELEM_W-1:0] e;
        int perm, cc;
        int sg;
        perm = $urandom_range(0, 5);
        for (int r = 0; r < 3; r++) begin
            cc = (perm < 3) ? (r + perm) % 3 : (perm - r + 3) % 3;
            for (int c = 0; c < 3; c++) begin
                sg = $urandom_range(0, 1) ? 16384 : -16384;
                if (c == cc)
                    e[r*3+c] = jitter(sg * $urandom_range(1, 4) / 4);
                else
                    e[r*3+c] = jitter(int'($urandom_range(0, 16384)) - 8192);
            end
        end
        return pack9(e);
    endfunction

    initial begin
        logic [8:0][ELEM_W-1:0] e;
        logic [IN_W-1:0] mat;
        calm     = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        idle_cnt = 0;
        aresetn  = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: identity, axis flips, extremes and degenerate inputs
        e = '0; e[0] = ONE; e[4] = ONE; e[8] = ONE; send_matrix(pack9(e));
        e = '0; e[0] = ONE; e[4] = -ONE; e[8] = -ONE; send_matrix(pack9(e));
        e = '0; e[0] = -ONE; e[4] = ONE; e[8] = -ONE; send_matrix(pack9(e));
        e = '0; e[0] = -ONE; e[4] = -ONE; e[8] = ONE; send_matrix(pack9(e));
        e = '0; e[1] = -ONE; e[3] = ONE; e[8] = ONE; send_matrix(pack9(e));
        send_matrix('0);
        send_matrix({IN_W{1'b1}});
        for (int k = 0; k < 9; k++) e[k] = Q_MAX;
        send_matrix(pack9(e));
        for (int k = 0; k < 9; k++) e[k] = Q_MIN;
        send_matrix(pack9(e));
        e = '0; e[0] = Q_MIN; e[4] = Q_MIN; e[8] = Q_MIN; send_matrix(pack9(e));
        e = '0; e[0] = Q_MAX; e[4] = Q_MAX; e[8] = Q_MAX;
        e[5] = Q_MAX; e[7] = Q_MIN; e[6] = Q_MIN; e[2] = Q_MAX;
        send_matrix(pack9(e));
        e = '0; e[0] = Q_MIN; e[4] = Q_MAX; e[8] = Q_MAX; send_matrix(pack9(e));
        e = '0; e[0] = -ONE; e[4] = -ONE; e[8] = -ONE; send_matrix(pack9(e));
        for (int k = 0; k < 9; k++) e[k] = 16'h5555;
        send_matrix(pack9(e));
        for (int k = 0; k < 9; k++) e[k] = 16'hAAAA;
        send_matrix(pack9(e));
        // equal diagonals on the non-positive trace path
        e = '0; e[0] = -16'sd100; e[4] = -16'sd100; e[8] = -16'sd100;
        e[1] = Q_MAX; e[3] = Q_MAX; send_matrix(pack9(e));

        // drain completely before the random part
        s_tvalid <= 1'b0;
        wait (n_waiting == 0);
        @(negedge aclk);

        for (int n = 0; n < N_RAND; n++) begin
            if (n == N_RAND - 100) calm = 1'b1;
            case ($urandom_range(0, 9))
                0, 1:    mat = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
                default: mat = near_rotation();
            endcase
            send_matrix(mat);
        end

        // drain and settle
        s_tvalid <= 1'b0;
        wait (n_waiting == 0);
        repeat (60) @(posedge aclk);
        if (n_fail == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
